[rtl/core/pcpa_pkg.sv]
package pcpa_pkg;

    localparam int ADDR_W    = 32;
    localparam int STEAL_W   = 13;
    localparam int CPU_W     = 3;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Operation codes
    localparam logic OP_FREE  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_FREED   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_GRANTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OOM     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD     = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_START   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_STOP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEAL_BATCH = 2'd2;

    // Register reset values
    localparam logic [ADDR_W-1:0]  MEM_START_RESET   = 32'h8000_0000;
    localparam logic [ADDR_W-1:0]  MEM_STOP_RESET    = 32'h8800_0000;
    localparam logic [STEAL_W-1:0] STEAL_BATCH_RESET = 13'd64;

endpackage

[rtl/core/pcpa_ram.sv]
module pcpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/core/per_cpu_page_allocator_steal_unit.sv]
// Per-CPU free-list page allocator with work stealing.
//
// Input channel (s_*): one transaction per request. s_operation selects free
// or alloc, s_cpu names the requesting CPU, s_address is the page to free.
// Result channel (m_*): exactly one transaction per request with a status
// and, for a grant, the page address (zero otherwise).
// Config port: cfg_wr_en/cfg_index/cfg_wdata write mem_start, mem_stop or
// steal_batch, one register per write; write only while the block is idle.
//
// Sequence: a free passes FREE_CHK, FREE_PUSH and RESP from the accept to the
// loaded result register, an alloc from a non-empty list ALLOC, SCAN, POP_CHK,
// POP and RESP. An alloc on an empty list first steals: SCAN steps through the
// CPU indexes, each page moved adds a MOVE state, and then POP_CHK follows.
// Each move reads the donor's link and then writes the moved link.
// One request is in flight at a time; s_ready is high in the idle state,
// even while a previous result still waits in the output register.
// Reset: all lists are empty, registers take their reset values, the link
// memory is not cleared (a link is always written before it is read).
// A stalled receiver holds the result register; the next request is then
// taken but its result waits until the output register drains.
module per_cpu_page_allocator_steal_unit #(
    parameter int CPU_COUNT  = 8,
    parameter int PAGE_COUNT = 32768,
    parameter int PAGE_SHIFT = 12
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_wr_en,
    input  logic [pcpa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pcpa_pkg::ADDR_W-1:0]           cfg_wdata,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_operation,
    input  logic [pcpa_pkg::CPU_W-1:0]            s_cpu,
    input  logic [pcpa_pkg::ADDR_W-1:0]           s_address,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [pcpa_pkg::STATUS_W-1:0]         m_status,
    output logic [pcpa_pkg::ADDR_W-1:0]           m_page_address
);

    // Widths derived from the parameters
    localparam int PW = $clog2(PAGE_COUNT);                    // page index
    localparam int CI = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1; // head array index
    localparam int CW = $clog2(CPU_COUNT + 1);                 // donor counter
    localparam int BW = 33 - PAGE_SHIFT;                       // base page number
    localparam int IW = BW + 1;                                // free index difference

    localparam logic [pcpa_pkg::ADDR_W-1:0] PAGE_MASK =
        32'((64'd1 << PAGE_SHIFT) - 64'd1);
    localparam logic [BW-1:0] BASE_RESET =
        BW'((33'(pcpa_pkg::MEM_START_RESET) + 33'(PAGE_MASK)) >> PAGE_SHIFT);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FREE_CHK,
        ST_FREE_PUSH,
        ST_ALLOC,
        ST_SCAN,
        ST_MOVE,
        ST_POP_CHK,
        ST_POP,
        ST_RESP
    } state_t;

    // Control state
    state_t                              state_reg, state_next;
    logic                                m_valid_reg, m_valid_next;
    logic [pcpa_pkg::STATUS_W-1:0]       m_status_reg, m_status_next;
    logic [pcpa_pkg::ADDR_W-1:0]         m_addr_reg, m_addr_next;
    logic [pcpa_pkg::ADDR_W-1:0]         mem_start_reg, mem_start_next;
    logic [pcpa_pkg::ADDR_W-1:0]         mem_stop_reg, mem_stop_next;
    logic [pcpa_pkg::STEAL_W-1:0]        steal_batch_reg, steal_batch_next;
    logic [BW-1:0]                       base_reg, base_next;
    logic [CPU_COUNT-1:0]                hvalid_reg, hvalid_next;
    logic [CW-1:0]                       d_reg, d_next;
    logic [pcpa_pkg::STEAL_W-1:0]        left_reg, left_next;

    // Payload state
    logic [pcpa_pkg::CPU_W-1:0]          cpu_reg, cpu_next;
    logic [pcpa_pkg::ADDR_W-1:0]         addr_reg, addr_next;
    logic                                bad_reg, bad_next;
    logic [IW-1:0]                       idx_wide_reg, idx_wide_next;
    logic [PW-1:0]                       mv_idx_reg, mv_idx_next;
    logic [pcpa_pkg::STATUS_W-1:0]       res_status_reg, res_status_next;
    logic [pcpa_pkg::ADDR_W-1:0]         res_addr_reg, res_addr_next;
    logic [PW-1:0]                       head_reg [CPU_COUNT];
    logic [PW-1:0]                       head_next [CPU_COUNT];

    // Link memory: {valid, next page index} per page
    logic                                ram_we;
    logic [PW-1:0]                       ram_waddr;
    logic [PW:0]                         ram_wdata;
    logic [PW:0]                         ram_rdata;

    // Datapath helpers
    logic [CI-1:0]                       c_idx, d_idx, rd_cpu;
    logic [PW-1:0]                       head_rd;
    logic                                hv_rd;
    logic                                cpu_bad;
    logic [pcpa_pkg::ADDR_W-1:0]         grant_sum;
    logic [pcpa_pkg::STEAL_W-1:0]        left_dec;

    pcpa_ram #(
        .WIDTH (PW + 1),
        .DEPTH (PAGE_COUNT)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (head_rd),
        .rd_data (ram_rdata)
    );

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_page_address = m_addr_reg;

    assign c_idx     = CI'(cpu_reg);
    assign d_idx     = CI'(d_reg);
    // Scan looks at the donor; every other state looks at the requester
    assign rd_cpu    = (state_reg == ST_SCAN) ? d_idx : c_idx;
    assign head_rd   = head_reg[rd_cpu];
    assign hv_rd     = hvalid_reg[rd_cpu];
    assign cpu_bad   = (32'(cpu_reg) >= 32'(CPU_COUNT));
    assign grant_sum = 32'(base_reg) + 32'(mv_idx_reg);
    assign left_dec  = left_reg - 1'b1;

    always_comb begin
        state_next       = state_reg;
        m_valid_next     = m_valid_reg;
        m_status_next    = m_status_reg;
        m_addr_next      = m_addr_reg;
        mem_start_next   = mem_start_reg;
        mem_stop_next    = mem_stop_reg;
        steal_batch_next = steal_batch_reg;
        base_next        = base_reg;
        hvalid_next      = hvalid_reg;
        d_next           = d_reg;
        left_next        = left_reg;
        cpu_next         = cpu_reg;
        addr_next        = addr_reg;
        bad_next         = bad_reg;
        idx_wide_next    = idx_wide_reg;
        mv_idx_next      = mv_idx_reg;
        res_status_next  = res_status_reg;
        res_addr_next    = res_addr_reg;
        head_next        = head_reg;
        ram_we           = 1'b0;
        ram_waddr        = mv_idx_reg;
        ram_wdata        = {hv_rd, head_rd};

        // Configuration writes; base page is kept precomputed
        if (cfg_wr_en) begin
            unique case (cfg_index)
                pcpa_pkg::CFG_MEM_START: begin
                    mem_start_next = cfg_wdata;
                    base_next = BW'((33'(cfg_wdata) + 33'(PAGE_MASK)) >> PAGE_SHIFT);
                end
                pcpa_pkg::CFG_MEM_STOP:    mem_stop_next = cfg_wdata;
                pcpa_pkg::CFG_STEAL_BATCH: steal_batch_next = cfg_wdata[pcpa_pkg::STEAL_W-1:0];
                default: ;
            endcase
        end

        // Drop the result once the receiver takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cpu_next   = s_cpu;
                    addr_next  = s_address;
                    state_next = (s_operation == pcpa_pkg::OP_FREE) ? ST_FREE_CHK : ST_ALLOC;
                end
            end
            ST_FREE_CHK: begin
                bad_next = cpu_bad
                         || ((addr_reg & PAGE_MASK) != '0)
                         || (addr_reg < mem_start_reg)
                         || (addr_reg >= mem_stop_reg);
                idx_wide_next = IW'(addr_reg >> PAGE_SHIFT) - IW'(base_reg);
                state_next    = ST_FREE_PUSH;
            end
            ST_FREE_PUSH: begin
                res_addr_next = '0;
                if (bad_reg || (34'(idx_wide_reg) >= 34'(PAGE_COUNT))) begin
                    res_status_next = pcpa_pkg::STATUS_BAD;
                end else begin
                    // Link the page to the old head, then make it the head
                    ram_we             = 1'b1;
                    ram_waddr          = PW'(idx_wide_reg);
                    head_next[c_idx]   = PW'(idx_wide_reg);
                    hvalid_next[c_idx] = 1'b1;
                    res_status_next    = pcpa_pkg::STATUS_FREED;
                end
                state_next = ST_RESP;
            end
            ST_ALLOC: begin
                if (cpu_bad) begin
                    res_status_next = pcpa_pkg::STATUS_OOM;
                    res_addr_next   = '0;
                    state_next      = ST_RESP;
                end else begin
                    left_next  = hv_rd ? '0 : steal_batch_reg;
                    d_next     = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if ((left_reg == '0) || (32'(d_reg) == 32'(CPU_COUNT))) begin
                    state_next = ST_POP_CHK;
                end else if ((d_reg == CW'(cpu_reg)) || !hv_rd) begin
                    d_next = d_reg + 1'b1;
                end else begin
                    // Donor head goes out on the link read this cycle
                    mv_idx_next = head_rd;
                    state_next  = ST_MOVE;
                end
            end
            ST_MOVE: begin
                head_next[d_idx]   = ram_rdata[PW-1:0];
                hvalid_next[d_idx] = ram_rdata[PW];
                ram_we             = 1'b1;
                head_next[c_idx]   = mv_idx_reg;
                hvalid_next[c_idx] = 1'b1;
                left_next          = left_dec;
                state_next         = ST_SCAN;
            end
            ST_POP_CHK: begin
                if (!hv_rd) begin
                    res_status_next = pcpa_pkg::STATUS_OOM;
                    res_addr_next   = '0;
                    state_next      = ST_RESP;
                end else begin
                    mv_idx_next = head_rd;
                    state_next  = ST_POP;
                end
            end
            ST_POP: begin
                head_next[c_idx]   = ram_rdata[PW-1:0];
                hvalid_next[c_idx] = ram_rdata[PW];
                res_status_next    = pcpa_pkg::STATUS_GRANTED;
                res_addr_next      = grant_sum << PAGE_SHIFT;
                state_next         = ST_RESP;
            end
            ST_RESP: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_addr_next   = res_addr_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            m_status_reg    <= pcpa_pkg::STATUS_FREED;
            m_addr_reg      <= '0;
            mem_start_reg   <= pcpa_pkg::MEM_START_RESET;
            mem_stop_reg    <= pcpa_pkg::MEM_STOP_RESET;
            steal_batch_reg <= pcpa_pkg::STEAL_BATCH_RESET;
            base_reg        <= BASE_RESET;
            hvalid_reg      <= '0;
            d_reg           <= '0;
            left_reg        <= '0;
        end else begin
            state_reg       <= state_next;
            m_valid_reg     <= m_valid_next;
            m_status_reg    <= m_status_next;
            m_addr_reg      <= m_addr_next;
            mem_start_reg   <= mem_start_next;
            mem_stop_reg    <= mem_stop_next;
            steal_batch_reg <= steal_batch_next;
            base_reg        <= base_next;
            hvalid_reg      <= hvalid_next;
            d_reg           <= d_next;
            left_reg        <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        cpu_reg        <= cpu_next;
        addr_reg       <= addr_next;
        bad_reg        <= bad_next;
        idx_wide_reg   <= idx_wide_next;
        mv_idx_reg     <= mv_idx_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        head_reg       <= head_next;
    end

`ifndef ASSERT_OFF
    // Only a grant carries a page address
    a_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != pcpa_pkg::STATUS_GRANTED) |-> m_page_address == '0)
        else $error("non-grant result carries a page address");

    // A donor is never the requester itself
    a_donor_not_self: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MOVE |-> d_reg != CW'(cpu_reg))
        else $error("steal picked the requesting CPU as donor");

    // Every page move spends one unit of the steal budget
    a_budget: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MOVE |=> left_reg == $past(left_dec))
        else $error("steal budget not decremented on a page move");

    // After a move the requester's list is non-empty
    a_req_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MOVE |=> hvalid_reg[c_idx])
        else $error("requester list empty after a page move");
`endif

endmodule

[verif/per_cpu_page_allocator_steal_unit_tb.sv]
module per_cpu_page_allocator_steal_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CPU_COUNT  = 8;
    localparam int PAGE_COUNT = 32768;
    localparam int PAGE_SHIFT = 12;
    localparam int IDX_W      = $clog2(PAGE_COUNT);
    localparam logic [pcpa_pkg::ADDR_W-1:0] PAGE_MASK = (32'd1 << PAGE_SHIFT) - 32'd1;
    localparam logic [pcpa_pkg::ADDR_W-1:0] PAGE_SIZE = 32'd1 << PAGE_SHIFT;

    // One request transaction and one result transaction.
    typedef struct packed {
        logic                         op;
        logic [pcpa_pkg::CPU_W-1:0]   cpu;
        logic [pcpa_pkg::ADDR_W-1:0]  addr;
    } page_req_t;

    typedef struct packed {
        logic [pcpa_pkg::STATUS_W-1:0] status;
        logic [pcpa_pkg::ADDR_W-1:0]   page_address;
    } page_reply_t;

    // DUT ports; every input has a known value from time zero.
    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [pcpa_pkg::CFG_IDX_W-1:0]  cfg_index = pcpa_pkg::CFG_MEM_START;
    logic [pcpa_pkg::ADDR_W-1:0]     cfg_wdata = '0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    logic                            s_operation = pcpa_pkg::OP_FREE;
    logic [pcpa_pkg::CPU_W-1:0]      s_cpu     = '0;
    logic [pcpa_pkg::ADDR_W-1:0]     s_address = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    logic [pcpa_pkg::STATUS_W-1:0]   m_status;
    logic [pcpa_pkg::ADDR_W-1:0]     m_page_address;

    // Requests waiting to be driven, and replies the allocator still owes us.
    page_req_t   req_q[$];
    page_reply_t owed_replies[$];

    // Shadow of the allocator: registers, list heads and the link memory.
    logic [pcpa_pkg::ADDR_W-1:0]   mem_start_q   = pcpa_pkg::MEM_START_RESET;
    logic [pcpa_pkg::ADDR_W-1:0]   mem_stop_q    = pcpa_pkg::MEM_STOP_RESET;
    logic [pcpa_pkg::STEAL_W-1:0]  steal_batch_q = pcpa_pkg::STEAL_BATCH_RESET;
    logic [IDX_W-1:0]    head_page [CPU_COUNT];
    bit                  head_live [CPU_COUNT];
    logic [IDX_W-1:0]    next_page [PAGE_COUNT];
    bit                  next_live [PAGE_COUNT];

    // When set, neither side inserts idle cycles.
    bit steady = 1'b0;
    int error_count = 0;

    per_cpu_page_allocator_steal_unit #(
        .CPU_COUNT  (CPU_COUNT),
        .PAGE_COUNT (PAGE_COUNT),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_cpu          (s_cpu),
        .s_address      (s_address),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_page_address (m_page_address)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Hard stop in case the allocator hangs or drops a transaction.
    initial begin
        #50_000_000;
        $display("per_cpu_page_allocator_steal_unit_tb: done, errors");
        $finish;
    end

    // Page number of the first allocatable page: mem_start rounded up.
    function automatic logic [63:0] first_page();
        logic [63:0] start;
        start = {32'd0, mem_start_q};
        return (start + {32'd0, PAGE_MASK}) >> PAGE_SHIFT;
    endfunction

    // Physical address of page index idx under the current mem_start, truncated.
    function automatic logic [pcpa_pkg::ADDR_W-1:0] page_addr(input logic [63:0] idx);
        logic [63:0] full;
        full = (first_page() + idx) << PAGE_SHIFT;
        return full[pcpa_pkg::ADDR_W-1:0];
    endfunction

    function automatic void push_page(input int c, input logic [IDX_W-1:0] pg);
        next_page[pg] = head_page[c];
        next_live[pg] = head_live[c];
        head_page[c]  = pg;
        head_live[c]  = 1'b1;
    endfunction

    // Caller makes sure the list of c is not empty.
    function automatic logic [IDX_W-1:0] pop_page(input int c);
        logic [IDX_W-1:0] pg;
        pg = head_page[c];
        head_page[c] = next_page[pg];
        head_live[c] = next_live[pg];
        return pg;
    endfunction

    // Apply one request to the shadow lists and return the reply it earns.
    function automatic page_reply_t predict_reply(input page_req_t req);
        page_reply_t      rep;
        logic [63:0]      base;
        logic [63:0]      idx;
        logic [IDX_W-1:0] pg;
        int               c;
        int               d;
        int unsigned      left;
        rep.status       = pcpa_pkg::STATUS_FREED;
        rep.page_address = '0;
        base = first_page();
        c    = int'(req.cpu);
        if (req.op == pcpa_pkg::OP_FREE) begin
            if (c >= CPU_COUNT || (req.addr & PAGE_MASK) != 0 ||
                req.addr < mem_start_q || req.addr >= mem_stop_q) begin
                rep.status = pcpa_pkg::STATUS_BAD;
            end else begin
                idx = ({32'd0, req.addr} >> PAGE_SHIFT) - base;
                if (idx >= PAGE_COUNT) begin
                    rep.status = pcpa_pkg::STATUS_BAD;
                end else begin
                    push_page(c, idx[IDX_W-1:0]);
                end
            end
            return rep;
        end
        if (c >= CPU_COUNT) begin
            rep.status = pcpa_pkg::STATUS_OOM;
            return rep;
        end
        // Empty own list: pull pages one at a time from the other CPUs, in order.
        if (!head_live[c]) begin
            left = 32'(steal_batch_q);
            for (d = 0; d < CPU_COUNT && left != 0; d++) begin
                if (d != c) begin
                    while (head_live[d] && left != 0) begin
                        push_page(c, pop_page(d));
                        left--;
                    end
                end
            end
        end
        if (!head_live[c]) begin
            rep.status = pcpa_pkg::STATUS_OOM;
        end else begin
            pg = pop_page(c);
            rep.status       = pcpa_pkg::STATUS_GRANTED;
            rep.page_address = page_addr({{(64-IDX_W){1'b0}}, pg});
        end
        return rep;
    endfunction

    task automatic flag_mismatch(input string what,
                                 input logic [pcpa_pkg::ADDR_W-1:0] want,
                                 input logic [pcpa_pkg::ADDR_W-1:0] got);
        if (error_count < 10)
            $display("mismatch at %0t: %s: expected %h, got %h", $realtime, what, want, got);
        error_count++;
    endtask

    // Driver: present queued requests, hold each until it is taken, and
    // predict the reply at the edge where the transaction completes.
    always @(posedge aclk) begin : drive_requests
        page_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                owed_replies.push_back(predict_reply('{s_operation, s_cpu, s_address}));
            end
            // Advance only when the slot is empty or its transaction just went through.
            if (!s_valid || s_ready) begin
                if (req_q.size() != 0 && (steady || $urandom_range(99) >= 25)) begin
                    nxt = req_q.pop_front();
                    s_valid     <= 1'b1;
                    s_operation <= nxt.op;
                    s_cpu       <= nxt.cpu;
                    s_address   <= nxt.addr;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall the result channel at random and compare every
    // completed result transaction with the oldest owed reply.
    always @(posedge aclk) begin : check_replies
        page_reply_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (owed_replies.size() == 0) begin
                    flag_mismatch("result with nothing outstanding", '0, m_page_address);
                end else begin
                    want = owed_replies.pop_front();
                    if (m_status !== want.status)
                        flag_mismatch("status", pcpa_pkg::ADDR_W'(want.status),
                                      pcpa_pkg::ADDR_W'(m_status));
                    if (m_page_address !== want.page_address)
                        flag_mismatch("page_address", want.page_address, m_page_address);
                end
            end
            m_ready <= steady || ($urandom_range(99) >= 25);
        end
    end

    task automatic add_req(input logic op, input int cpu,
                           input logic [pcpa_pkg::ADDR_W-1:0] addr);
        req_q.push_back('{op, cpu[pcpa_pkg::CPU_W-1:0], addr});
    endtask

    // Write one register; only called while the allocator is idle.
    task automatic set_reg(input logic [pcpa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pcpa_pkg::ADDR_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            pcpa_pkg::CFG_MEM_START:   mem_start_q   = val;
            pcpa_pkg::CFG_MEM_STOP:    mem_stop_q    = val;
            pcpa_pkg::CFG_STEAL_BATCH: steal_batch_q = val[pcpa_pkg::STEAL_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Hold the sender until every request is taken and every reply is back,
    // then let the allocator sit idle. Sample on the falling edge
    // so the queues are settled.
    task automatic settle();
        do @(negedge aclk);
        while (req_q.size() != 0 || s_valid || owed_replies.size() != 0);
        repeat (12) @(negedge aclk);
    endtask

    // Mostly valid frees from a small pool of pages plus allocs, so lists fill,
    // drain and get stolen from; the rest is bad addresses of every kind.
    task automatic queue_random(input int n);
        int          kind;
        int          r;
        logic [63:0] idx;
        logic [pcpa_pkg::ADDR_W-1:0] addr;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(99);
            r    = $urandom_range(99);
            if (r < 70)
                idx = 64'($urandom_range(47));
            else if (r < 85)
                idx = 64'(PAGE_COUNT - 1 - $urandom_range(7));
            else
                idx = 64'($urandom_range(PAGE_COUNT - 1));
            if (kind < 45) begin
                add_req(pcpa_pkg::OP_FREE, $urandom_range(CPU_COUNT - 1), page_addr(idx));
            end else if (kind < 85) begin
                add_req(pcpa_pkg::OP_ALLOC, $urandom_range(CPU_COUNT - 1), $urandom);
            end else begin
                case ($urandom_range(4))
                    0: addr = page_addr(idx) |
                              pcpa_pkg::ADDR_W'($urandom_range(PAGE_SIZE - 1, 1));
                    1: addr = mem_start_q - PAGE_SIZE * $urandom_range(4, 1);
                    2: addr = (mem_stop_q & ~PAGE_MASK) + PAGE_SIZE * $urandom_range(3);
                    3: addr = $urandom;
                    default: addr = page_addr(64'(PAGE_COUNT + $urandom_range(3)));
                endcase
                add_req(pcpa_pkg::OP_FREE, $urandom_range(CPU_COUNT - 1), addr);
            end
        end
    endtask

    initial begin
        // Hold reset once, at the start.
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset registers: empty lists, every kind of bad free, first and
        // last page, a steal, an exhausted system and a double free.
        add_req(pcpa_pkg::OP_ALLOC, 0, 32'h0000_0000);
        add_req(pcpa_pkg::OP_FREE,  0, 32'h8000_0001);
        add_req(pcpa_pkg::OP_FREE,  0, 32'h7FFF_F000);
        add_req(pcpa_pkg::OP_FREE,  1, 32'h8800_0000);
        add_req(pcpa_pkg::OP_FREE,  7, 32'hFFFF_FFFF);
        add_req(pcpa_pkg::OP_FREE,  0, 32'h8000_0000);
        add_req(pcpa_pkg::OP_FREE,  7, 32'h87FF_F000);
        add_req(pcpa_pkg::OP_ALLOC, 0, 32'hFFFF_FFFF);
        add_req(pcpa_pkg::OP_ALLOC, 0, 32'h0000_0000);
        add_req(pcpa_pkg::OP_FREE,  1, 32'h8000_1000);
        add_req(pcpa_pkg::OP_FREE,  2, 32'h8000_2000);
        add_req(pcpa_pkg::OP_FREE,  2, 32'h8000_3000);
        add_req(pcpa_pkg::OP_FREE,  3, 32'h8000_4000);
        add_req(pcpa_pkg::OP_ALLOC, 5, 32'h0000_0000);
        add_req(pcpa_pkg::OP_ALLOC, 5, 32'h0000_0000);
        add_req(pcpa_pkg::OP_ALLOC, 5, 32'h0000_0000);
        add_req(pcpa_pkg::OP_ALLOC, 5, 32'h0000_0000);
        add_req(pcpa_pkg::OP_ALLOC, 5, 32'h0000_0000);
        add_req(pcpa_pkg::OP_FREE,  6, 32'h8001_0000);
        add_req(pcpa_pkg::OP_FREE,  6, 32'h8001_0000);
        add_req(pcpa_pkg::OP_ALLOC, 6, 32'h0000_0000);
        add_req(pcpa_pkg::OP_ALLOC, 6, 32'h0000_0000);
        settle();

        // Whole address space, a steal batch of 4096, index past the page count.
        set_reg(pcpa_pkg::CFG_MEM_START,   32'h0000_0000);
        set_reg(pcpa_pkg::CFG_MEM_STOP,    32'hFFFF_FFFF);
        set_reg(pcpa_pkg::CFG_STEAL_BATCH, 32'd4096);
        @(negedge aclk);
        add_req(pcpa_pkg::OP_FREE,  3, 32'h0000_0000);
        add_req(pcpa_pkg::OP_FREE,  6, 32'h07FF_F000);
        add_req(pcpa_pkg::OP_FREE,  6, 32'h0800_0000);
        add_req(pcpa_pkg::OP_FREE,  4, 32'h0000_5000);
        add_req(pcpa_pkg::OP_ALLOC, 1, 32'h0000_0000);
        settle();

        // Zero batch: an empty list cannot borrow.
        set_reg(pcpa_pkg::CFG_STEAL_BATCH, 32'd0);
        @(negedge aclk);
        add_req(pcpa_pkg::OP_ALLOC, 2, 32'h0000_0000);
        settle();

        // Top of the address space: listed pages wrap, every free is rejected.
        set_reg(pcpa_pkg::CFG_MEM_START,   32'hFFFF_FFFF);
        set_reg(pcpa_pkg::CFG_MEM_STOP,    32'hFFFF_FFFF);
        set_reg(pcpa_pkg::CFG_STEAL_BATCH, 32'd1);
        @(negedge aclk);
        add_req(pcpa_pkg::OP_ALLOC, 4, 32'h0000_0000);
        add_req(pcpa_pkg::OP_FREE,  4, 32'hFFFF_F000);
        settle();

        // Random part, reset-like window; drain once halfway through.
        set_reg(pcpa_pkg::CFG_MEM_START,   pcpa_pkg::MEM_START_RESET);
        set_reg(pcpa_pkg::CFG_MEM_STOP,    pcpa_pkg::MEM_STOP_RESET);
        set_reg(pcpa_pkg::CFG_STEAL_BATCH, 32'(pcpa_pkg::STEAL_BATCH_RESET));
        @(negedge aclk);
        queue_random(75);
        settle();
        queue_random(75);
        settle();

        // Unaligned start, tiny window, small batches.
        set_reg(pcpa_pkg::CFG_MEM_START,   32'h0000_1001);
        set_reg(pcpa_pkg::CFG_MEM_STOP,    32'h0004_1001);
        set_reg(pcpa_pkg::CFG_STEAL_BATCH, $urandom_range(8, 1));
        @(negedge aclk);
        queue_random(150);
        settle();

        // Random aligned window, no idling on either side.
        set_reg(pcpa_pkg::CFG_MEM_START,
                {12'(0), 20'($urandom_range(32'hF7FFF))} << PAGE_SHIFT);
        set_reg(pcpa_pkg::CFG_MEM_STOP,    mem_start_q + 32'h0800_0000);
        set_reg(pcpa_pkg::CFG_STEAL_BATCH, $urandom_range(16, 1));
        @(negedge aclk);
        steady = 1'b1;
        queue_random(150);
        settle();
        steady = 1'b0;

        // Arbitrary registers, possibly an inverted window.
        set_reg(pcpa_pkg::CFG_MEM_START,   $urandom);
        set_reg(pcpa_pkg::CFG_MEM_STOP,    $urandom);
        set_reg(pcpa_pkg::CFG_STEAL_BATCH, $urandom_range(64));
        @(negedge aclk);
        queue_random(150);
        settle();

        // Back to the reset window for the last stretch.
        set_reg(pcpa_pkg::CFG_MEM_START,   pcpa_pkg::MEM_START_RESET);
        set_reg(pcpa_pkg::CFG_MEM_STOP,    pcpa_pkg::MEM_STOP_RESET);
        set_reg(pcpa_pkg::CFG_STEAL_BATCH, 32'd3);
        @(negedge aclk);
        queue_random(150);
        settle();

        // Give any stray result time to show up, then report.
        repeat (40) @(posedge aclk);
        error_count += owed_replies.size();
        if (error_count == 0)
            $display("per_cpu_page_allocator_steal_unit_tb: done, clean");
        else
            $display("per_cpu_page_allocator_steal_unit_tb: done, errors");
        $finish;
    end

endmodule

[files.f]
rtl/core/pcpa_pkg.sv
rtl/core/pcpa_ram.sv
rtl/core/per_cpu_page_allocator_steal_unit.sv
verif/per_cpu_page_allocator_steal_unit_tb.sv
